[rtl/npm_pkg.sv]
`default_nettype none

package npm_pkg;

    localparam int COORD_W = 20;
    localparam int SQ_W    = 2 * COORD_W;
    localparam int DIST_W  = SQ_W + 1;
    localparam int INDEX_W = 10;
    localparam int REQ_W   = 2;

    localparam logic [REQ_W-1:0] REQ_LOAD  = 2'd0;
    localparam logic [REQ_W-1:0] REQ_QUERY = 2'd1;
    localparam logic [REQ_W-1:0] REQ_CLEAR = 2'd2;

    typedef logic [COORD_W-1:0] coord_t;
    typedef logic [DIST_W-1:0]  dist_t;

    typedef struct packed {
        coord_t x;
        coord_t y;
    } point_t;

endpackage

`default_nettype wire

[rtl/npm_sqdist.sv]
`default_nettype none

// Three-stage squared distance: |a-b| per axis, squares, sum.
// A tag travels alongside each operand pair.
module npm_sqdist #(
    parameter int TAG_W = 11
) (
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                in_valid,
    input  wire logic [TAG_W-1:0]    in_tag,
    input  wire npm_pkg::point_t     ref_pt,
    input  wire npm_pkg::point_t     obj_pt,
    output logic                     out_valid,
    output logic [TAG_W-1:0]         out_tag,
    output npm_pkg::dist_t           out_dist
);
    import npm_pkg::*;

    logic [2:0]         valid_reg;
    logic [TAG_W-1:0]   tag1_reg, tag2_reg, tag3_reg;
    coord_t             dx_reg, dy_reg;
    logic [SQ_W-1:0]    sx_reg, sy_reg;
    dist_t              sum_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= {valid_reg[1:0], in_valid};
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1: absolute differences
        dx_reg   <= (ref_pt.x > obj_pt.x) ? (ref_pt.x - obj_pt.x) : (obj_pt.x - ref_pt.x);
        dy_reg   <= (ref_pt.y > obj_pt.y) ? (ref_pt.y - obj_pt.y) : (obj_pt.y - ref_pt.y);
        tag1_reg <= in_tag;
        // stage 2: squares
        sx_reg   <= SQ_W'(dx_reg) * SQ_W'(dx_reg);
        sy_reg   <= SQ_W'(dy_reg) * SQ_W'(dy_reg);
        tag2_reg <= tag1_reg;
        // stage 3: sum, exact in DIST_W bits
        sum_reg  <= DIST_W'(sx_reg) + DIST_W'(sy_reg);
        tag3_reg <= tag2_reg;
    end

    assign out_valid = valid_reg[2];
    assign out_tag   = tag3_reg;
    assign out_dist  = sum_reg;

endmodule

`default_nettype wire

[rtl/nearest_point_match_2d.sv]
`default_nettype none

// Channel   | Signals                                  | Transfer
// ----------+------------------------------------------+----------------------------------
// request   | start, req_type, point_x, point_y, busy  | rising edge with start && !busy
// result    | done, found, match_index,                | edge ending the cycle done is high
//           | distance_squared                         | (receiver cannot stall)
//
// Load and clear leave busy low. A query over n stored points holds busy
// while the scan reads one entry per cycle from the synchronous point memory
// and then while the memory read register and the three distance stages drain;
// done rises once the last entry leaves the distance pipe.
// An empty-store query answers on the next cycle. Reset clears the point count
// and the control state but not the point memory; memory contents are never read
// before being written, so no clearing pass is needed.
module nearest_point_match_2d #(
    parameter int MAX_REFERENCES = 1024
) (
    input  wire logic                       clk,
    input  wire logic                       rst_n,
    input  wire logic                       start,
    output logic                            busy,
    input  wire logic [npm_pkg::REQ_W-1:0]  req_type,
    input  wire npm_pkg::coord_t            point_x,
    input  wire npm_pkg::coord_t            point_y,
    output logic                            done,
    output logic                            found,
    output logic [npm_pkg::INDEX_W-1:0]     match_index,
    output npm_pkg::dist_t                  distance_squared
);
    import npm_pkg::*;

    localparam int IDX_W = (MAX_REFERENCES > 1) ? $clog2(MAX_REFERENCES) : 1;
    localparam int CNT_W = $clog2(MAX_REFERENCES + 1);
    localparam int TAG_W = IDX_W + 1;          // {last, index}
    localparam int EXT_W = IDX_W + INDEX_W;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN
    } state_t;

    state_t             state_reg;
    logic [CNT_W-1:0]   count_reg;
    logic [IDX_W-1:0]   addr_reg;
    logic [IDX_W-1:0]   last_addr_reg;
    point_t             obj_reg;

    // Best-so-far of the running scan
    logic               have_best_reg;
    logic [IDX_W-1:0]   best_idx_reg;
    dist_t              best_dist_reg;

    // Result registers
    logic               done_reg;
    logic               found_reg;
    logic [INDEX_W-1:0] match_index_reg;
    dist_t              dist_reg;

    // Point memory, one synchronous read port and one write port
    point_t             ref_mem [MAX_REFERENCES];
    point_t             rd_data_reg;
    logic               rd_valid_reg;
    logic [TAG_W-1:0]   rd_tag_reg;

    logic               accept;
    logic               scan_issue;
    logic               scan_last;
    logic               mem_wr;

    logic               sq_valid;
    logic [TAG_W-1:0]   sq_tag;
    dist_t              sq_dist;
    logic               take;
    logic [IDX_W-1:0]   sel_idx;
    dist_t              sel_dist;
    logic [EXT_W-1:0]   idx_ext;

    assign accept     = start && !busy;
    assign scan_issue = (state_reg == ST_SCAN);
    assign scan_last  = scan_issue && (addr_reg == last_addr_reg);
    assign mem_wr     = accept && (req_type == REQ_LOAD)
                        && (count_reg < CNT_W'(MAX_REFERENCES));

    always_ff @(posedge clk)
    begin
        if (mem_wr)
        begin
            ref_mem[count_reg[IDX_W-1:0]] <= '{x: point_x, y: point_y};
        end
        if (scan_issue)
        begin
            rd_data_reg <= ref_mem[addr_reg];
        end
        rd_tag_reg <= {scan_last, addr_reg};
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            rd_valid_reg <= 1'b0;
        end
        else
        begin
            rd_valid_reg <= scan_issue;
        end
    end

    npm_sqdist #(
        .TAG_W (TAG_W)
    ) u_sqdist (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (rd_valid_reg),
        .in_tag    (rd_tag_reg),
        .ref_pt    (rd_data_reg),
        .obj_pt    (obj_reg),
        .out_valid (sq_valid),
        .out_tag   (sq_tag),
        .out_dist  (sq_dist)
    );

    // Strict less-than keeps the earlier entry on a tie
    assign take     = !have_best_reg || (sq_dist < best_dist_reg);
    assign sel_idx  = take ? sq_tag[IDX_W-1:0] : best_idx_reg;
    assign sel_dist = take ? sq_dist : best_dist_reg;
    assign idx_ext  = EXT_W'(sel_idx);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            count_reg       <= '0;
            addr_reg        <= '0;
            last_addr_reg   <= '0;
            have_best_reg   <= 1'b0;
            done_reg        <= 1'b0;
            found_reg       <= 1'b0;
            match_index_reg <= '0;
            dist_reg        <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                ST_IDLE:
                begin
                    if (accept)
                    begin
                        case (req_type)
                            REQ_LOAD:
                            begin
                                if (mem_wr)
                                begin
                                    count_reg <= count_reg + 1'b1;
                                end
                            end
                            REQ_CLEAR:
                            begin
                                count_reg <= '0;
                            end
                            REQ_QUERY:
                            begin
                                if (count_reg == '0)
                                begin
                                    done_reg        <= 1'b1;
                                    found_reg       <= 1'b0;
                                    match_index_reg <= '0;
                                    dist_reg        <= '0;
                                end
                                else
                                begin
                                    addr_reg      <= '0;
                                    last_addr_reg <= IDX_W'(count_reg - 1'b1);
                                    have_best_reg <= 1'b0;
                                    state_reg     <= ST_SCAN;
                                end
                            end
                            default:
                            begin
                                // unused code: no effect
                            end
                        endcase
                    end
                end
                ST_SCAN:
                begin
                    addr_reg <= addr_reg + 1'b1;
                    if (scan_last)
                    begin
                        state_reg <= ST_DRAIN;
                    end
                end
                ST_DRAIN:
                begin
                    // last entry leaves the distance pipe: publish the result
                    if (sq_valid && sq_tag[TAG_W-1])
                    begin
                        done_reg        <= 1'b1;
                        found_reg       <= 1'b1;
                        match_index_reg <= idx_ext[INDEX_W-1:0];
                        dist_reg        <= sel_dist;
                        state_reg       <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase

            if (sq_valid)
            begin
                have_best_reg <= 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            obj_reg <= '{x: point_x, y: point_y};
        end
        if (sq_valid)
        begin
            best_idx_reg  <= sel_idx;
            best_dist_reg <= sel_dist;
        end
    end

    assign busy             = (state_reg != ST_IDLE);
    assign done             = done_reg;
    assign found            = found_reg;
    assign match_index      = match_index_reg;
    assign distance_squared = dist_reg;

    // A result strobe never overlaps a running scan
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result strobe while scan still running");

    // Empty-store answers carry zero fields
    a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (done && !found) |-> (match_index == '0 && distance_squared == '0))
        else $error("empty-store result with nonzero fields");

    // Only a query transfer starts a scan
    a_scan_cause: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(busy) |-> ($past(start) && $past(req_type) == REQ_QUERY))
        else $error("scan started without a query transfer");

    // Distance pipe output only while a query is in flight
    a_pipe_owned: assert property (@(posedge clk) disable iff (!rst_n)
        sq_valid |-> busy)
        else $error("distance pipe active outside a query");

endmodule

`default_nettype wire

[tb/sv/nearest_match_checker.sv]
`timescale 1ns / 1ps

// Watches both channels of nearest_point_match_2d. It keeps its own copy of
// the reference store and works out the nearest entry for every query transfer.
module nearest_match_checker
    import npm_pkg::*;
#(
    parameter int MAX_REFS = 1024
) (
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               start,
    input  wire logic               busy,
    input  wire logic [REQ_W-1:0]   req_type,
    input  wire coord_t             point_x,
    input  wire coord_t             point_y,
    input  wire logic               done,
    input  wire logic               found,
    input  wire logic [INDEX_W-1:0] match_index,
    input  wire dist_t              distance_squared,
    output int unsigned             mismatches,
    output int unsigned             outstanding
);

    typedef struct packed {
        logic               found;
        logic [INDEX_W-1:0] index;
        dist_t              gap;
    } match_t;

    coord_t      stored_x [MAX_REFS];
    coord_t      stored_y [MAX_REFS];
    int unsigned stored_count;
    match_t      expected_matches [$];

    initial
    begin
        mismatches  = 0;
        outstanding = 0;
    end

    function automatic dist_t squared_gap(coord_t ax, coord_t ay, coord_t bx, coord_t by);
        coord_t dx;
        coord_t dy;
        dx = (ax > bx) ? ax - bx : bx - ax;
        dy = (ay > by) ? ay - by : by - ay;
        return dist_t'(dx) * dist_t'(dx) + dist_t'(dy) * dist_t'(dy);
    endfunction

    // Strict less-than: on equal distances the earliest load wins.
    function automatic match_t find_nearest(coord_t qx, coord_t qy);
        match_t best;
        dist_t  d;
        best = '0;
        if (stored_count == 0)
        begin
            return best;
        end
        best.found = 1'b1;
        best.gap   = squared_gap(stored_x[0], stored_y[0], qx, qy);
        for (int unsigned i = 1; i < stored_count; i++)
        begin
            d = squared_gap(stored_x[i], stored_y[i], qx, qy);
            if (d < best.gap)
            begin
                best.gap   = d;
                best.index = INDEX_W'(i);
            end
        end
        return best;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : watch
        match_t want;
        if (!rst_n)
        begin
            stored_count = 0;
            expected_matches.delete();
        end
        else
        begin
            // result first: it can never belong to a transfer on this same edge
            if (done)
            begin
                if (expected_matches.size() == 0)
                begin
                    $error("unexpected result: found=%0b match_index=%0d distance_squared=%0d",
                           found, match_index, distance_squared);
                    mismatches++;
                end
                else
                begin
                    want = expected_matches.pop_front();
                    if (found !== want.found)
                    begin
                        $error("found: expected %0b, got %0b", want.found, found);
                        mismatches++;
                    end
                    if (match_index !== want.index)
                    begin
                        $error("match_index: expected %0d, got %0d", want.index, match_index);
                        mismatches++;
                    end
                    if (distance_squared !== want.gap)
                    begin
                        $error("distance_squared: expected %0d, got %0d",
                               want.gap, distance_squared);
                        mismatches++;
                    end
                end
            end
            if (start && !busy)
            begin
                case (req_type)
                    REQ_LOAD:
                    begin
                        if (stored_count < MAX_REFS)
                        begin
                            stored_x[stored_count] = point_x;
                            stored_y[stored_count] = point_y;
                            stored_count++;
                        end
                    end
                    REQ_QUERY: expected_matches.push_back(find_nearest(point_x, point_y));
                    REQ_CLEAR: stored_count = 0;
                    default: ;
                endcase
            end
        end
        outstanding = expected_matches.size();
    end

endmodule

[tb/sv/tb.sv]
`timescale 1ns / 1ps

// Stimulus and verdict for nearest_point_match_2d. Prediction and comparison
// live in nearest_match_checker, which sits beside the block on the same wires.
module tb;
    import npm_pkg::*;

    localparam int DEPTH        = 1024;
    localparam int RANDOM_ITEMS = 540;
    localparam int CYCLE        = 8;
    localparam int IDLE_PCT     = 16;

    // request code the block must ignore
    localparam logic [REQ_W-1:0] REQ_UNUSED = 2'd3;
    localparam coord_t COORD_MAX = '1;

    // coordinate flavors for the random part
    localparam int STYLE_FULL    = 0;   // anything in range
    localparam int STYLE_GRID    = 1;   // tiny grid, lots of equal distances
    localparam int STYLE_EXTREME = 2;   // corners and near-corners
    localparam int STYLE_CLUSTER = 3;   // tight cloud around mid-scale

    logic               clk;
    logic               rst_n;
    logic               start;
    logic               busy;
    logic [REQ_W-1:0]   req_type;
    coord_t             point_x;
    coord_t             point_y;
    logic               done;
    logic               found;
    logic [INDEX_W-1:0] match_index;
    dist_t              distance_squared;

    int unsigned mismatches;
    int unsigned outstanding;

    // our own view of how full the store is, used only to shape stimulus
    int unsigned held;
    // high while the sender runs back to back with no gaps
    bit          calm;

    initial
    begin
        clk = 1'b0;
        forever #(CYCLE / 2) clk = ~clk;
    end

    nearest_point_match_2d #(
        .MAX_REFERENCES(DEPTH)
    ) dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .point_x         (point_x),
        .point_y         (point_y),
        .done            (done),
        .found           (found),
        .match_index     (match_index),
        .distance_squared(distance_squared)
    );

    nearest_match_checker #(
        .MAX_REFS(DEPTH)
    ) checker_i (
        .clk             (clk),
        .rst_n           (rst_n),
        .start           (start),
        .busy            (busy),
        .req_type        (req_type),
        .point_x         (point_x),
        .point_y         (point_y),
        .done            (done),
        .found           (found),
        .match_index     (match_index),
        .distance_squared(distance_squared),
        .mismatches      (mismatches),
        .outstanding     (outstanding)
    );

    // Hard stop well past the slowest legal run (every query over a full store).
    initial
    begin
        #100_000_000;
        $display("nearest_point_match_2d: mismatch");
        $finish;
    end

    // Sender gap: start low, payload wiggling so the block must ignore it.
    task automatic pause_input(int unsigned cycles);
        @(negedge clk);
        start    <= 1'b0;
        req_type <= REQ_W'($urandom);
        point_x  <= coord_t'($urandom);
        point_y  <= coord_t'($urandom);
        repeat (cycles - 1) @(negedge clk);
    endtask

    // One request transfer. Inputs move on the falling edge; the transfer is
    // seen at the first rising edge with busy low. busy is read right after the
    // edge, before the block's own updates land, so this is the pre-edge value.
    task automatic send(logic [REQ_W-1:0] kind, coord_t x, coord_t y);
        if (!calm && $urandom_range(0, 99) < IDLE_PCT)
        begin
            pause_input($urandom_range(1, 6));
        end
        @(negedge clk);
        start    <= 1'b1;
        req_type <= kind;
        point_x  <= x;
        point_y  <= y;
        do @(posedge clk); while (busy);
        case (kind)
            REQ_LOAD:  if (held < DEPTH) held++;
            REQ_CLEAR: held = 0;
            default: ;
        endcase
    endtask

    function automatic coord_t pick_coord(int unsigned style);
        case (style)
            STYLE_GRID:    return coord_t'($urandom_range(0, 7));
            STYLE_EXTREME:
            begin
                case ($urandom_range(0, 3))
                    0:       return '0;
                    1:       return coord_t'(1);
                    2:       return COORD_MAX - 1;
                    default: return COORD_MAX;
                endcase
            end
            STYLE_CLUSTER: return coord_t'(20'h80000 + $urandom_range(0, 15));
            default:       return coord_t'($urandom);
        endcase
    endfunction

    initial
    begin : stimulus
        int unsigned made;
        int unsigned cap;
        int unsigned style;
        int unsigned roll;
        int unsigned waited;

        rst_n    = 1'b0;
        start    = 1'b0;
        req_type = REQ_LOAD;
        point_x  = '0;
        point_y  = '0;
        held     = 0;
        calm     = 1'b0;
        repeat (9) @(negedge clk);
        rst_n <= 1'b1;

        // ---- directed corner cases ----
        send(REQ_QUERY, 20'h12345, 20'h54321);       // empty store -> found 0
        send(REQ_UNUSED, COORD_MAX, COORD_MAX);      // ignored code
        send(REQ_LOAD, '0, '0);
        send(REQ_QUERY, '0, '0);                     // exact hit, distance 0
        send(REQ_QUERY, COORD_MAX, COORD_MAX);       // largest possible distance
        send(REQ_LOAD, COORD_MAX, COORD_MAX);
        send(REQ_QUERY, COORD_MAX, '0);              // equidistant: first load wins
        send(REQ_LOAD, '0, '0);                      // duplicate of entry 0
        send(REQ_QUERY, coord_t'(1), coord_t'(1));   // tie with duplicate
        send(REQ_QUERY, COORD_MAX - 1, COORD_MAX);   // nearest is the later entry
        send(REQ_CLEAR, COORD_MAX, COORD_MAX);
        send(REQ_QUERY, coord_t'(5), coord_t'(5));   // cleared -> found 0 again
        send(REQ_LOAD, COORD_MAX, '0);
        send(REQ_LOAD, '0, COORD_MAX);
        send(REQ_QUERY, COORD_MAX, COORD_MAX);       // tie across axes
        send(REQ_QUERY, 20'h80000, 20'h80000);
        send(REQ_CLEAR, '0, '0);
        send(REQ_UNUSED, '0, '0);
        send(REQ_QUERY, '0, '0);                     // still empty
        send(REQ_LOAD, 20'h00010, 20'h00010);
        send(REQ_QUERY, 20'h00018, 20'h00008);       // nonzero gap on both axes

        // ---- random traffic, mostly small stores that get cleared often ----
        made  = 0;
        cap   = 8;
        style = STYLE_FULL;
        while (made < RANDOM_ITEMS)
        begin
            calm = (made >= 240 && made < 340);
            if (made % 40 == 0)
            begin
                style = $urandom_range(STYLE_FULL, STYLE_CLUSTER);
            end
            roll = $urandom_range(0, 99);
            if (roll < 2)
            begin
                send(REQ_UNUSED, coord_t'($urandom), coord_t'($urandom));
            end
            else
            begin
                made++;
                if (roll < 7 || (held >= cap && roll >= 48))
                begin
                    send(REQ_CLEAR, coord_t'($urandom), coord_t'($urandom));
                    // now and then let the store grow well past a handful
                    cap = ($urandom_range(0, 9) == 0) ? $urandom_range(17, 160)
                                                      : $urandom_range(1, 16);
                end
                else if (roll < 48)
                begin
                    send(REQ_QUERY, pick_coord(style), pick_coord(style));
                end
                else
                begin
                    send(REQ_LOAD, pick_coord(style), pick_coord(style));
                end
            end
        end
        calm = 1'b0;

        // ---- closing queries over whatever the random part left ----
        send(REQ_QUERY, COORD_MAX, '0);
        send(REQ_QUERY, pick_coord(STYLE_FULL), pick_coord(STYLE_FULL));
        send(REQ_QUERY, pick_coord(STYLE_CLUSTER), pick_coord(STYLE_CLUSTER));
        send(REQ_CLEAR, COORD_MAX, '0);
        send(REQ_QUERY, '0, COORD_MAX);

        @(negedge clk);
        start <= 1'b0;

        // drain: wait until the checker has no result outstanding
        waited = 0;
        while (outstanding != 0 && waited < 4 * DEPTH)
        begin
            @(negedge clk);
            waited++;
        end
        if (outstanding != 0)
        begin
            $display("nearest_point_match_2d: mismatch");
        end
        else
        begin
            // catch any stray strobe after the last expected result
            repeat (16) @(negedge clk);
            if (mismatches == 0)
            begin
                $display("nearest_point_match_2d: match");
            end
            else
            begin
                $display("nearest_point_match_2d: mismatch");
            end
        end
        $finish;
    end

endmodule
